### sv/shm_pkg.sv
package shm_pkg;

    localparam int CHAR_W = 8;
    localparam int HASH_W = 32;
    localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;
    localparam logic signed [CHAR_W-1:0] LOWER_A = 8'sd97;
    localparam logic signed [CHAR_W-1:0] LOWER_Z = 8'sd122;
    localparam logic [HASH_W-1:0] CASE_OFFSET = 32'd32;

    typedef enum logic
    {
        FORM_AS_WRITTEN = 1'b0,
        FORM_CAPITALIZED = 1'b1
    } form_t;

    typedef struct packed
    {
        logic signed [CHAR_W-1:0] char_value;
        logic                     last_char;
    } char_item_t;

    typedef struct packed
    {
        logic       valid;
        char_item_t item;
    } stage_t;

    function automatic logic [HASH_W-1:0] hash_step(
        input logic [HASH_W-1:0] h,
        input logic [HASH_W-1:0] c
    );
        logic [HASH_W-1:0] prod;
        begin
            prod = h * HASH_MULT;
            return prod + c;
        end
    endfunction

endpackage

### sv/shm_if.sv
interface shm_char_if;
    import shm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CHAR_W-1:0] char_value;
    logic                     last_char;

    modport source(output valid, output char_value, output last_char, input ready);
    modport sink(input valid, input char_value, input last_char, output ready);
endinterface

interface shm_result_if;
    import shm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic                     matched_form;
    logic signed [HASH_W-1:0] word_hash;

    modport source(output valid, output found, output matched_form, output word_hash,
                   input ready);
    modport sink(input valid, input found, input matched_form, input word_hash,
                 output ready);
endinterface

### sv/shm_in_stage.sv
module shm_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    shm_char_if.sink         char_in,
    output shm_pkg::stage_t  stage,
    input  logic             advance
);
    import shm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       take;

    assign char_in.ready = !valid_reg || advance;
    assign take = char_in.valid && char_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_value <= char_in.char_value;
            item_reg.last_char  <= char_in.last_char;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;
endmodule

### sv/shm_hash_core.sv
module shm_hash_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  shm_pkg::stage_t                  stage,
    output logic                             advance,
    input  logic [shm_pkg::HASH_W-1:0]       target,
    shm_result_if.source                     result_out
);
    import shm_pkg::*;

    logic [HASH_W-1:0] plain_reg;
    logic [HASH_W-1:0] plain_next;
    logic [HASH_W-1:0] capital_reg;
    logic [HASH_W-1:0] capital_next;
    logic              start_reg;
    logic              start_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    form_t             form_reg;
    logic [HASH_W-1:0] hash_out_reg;

    logic [HASH_W-1:0] c_ext;
    logic [HASH_W-1:0] cc_ext;
    logic [HASH_W-1:0] plain_sum;
    logic [HASH_W-1:0] capital_sum;
    logic              is_lower;
    logic              plain_hit;
    logic              capital_hit;
    logic              emit;

    assign advance = stage.valid && (!out_valid_reg || result_out.ready);
    assign emit    = advance && stage.item.last_char;

    assign c_ext    = HASH_W'(stage.item.char_value);
    assign is_lower = (stage.item.char_value >= LOWER_A) && (stage.item.char_value <= LOWER_Z);
    assign cc_ext   = (start_reg && is_lower) ? (c_ext - CASE_OFFSET) : c_ext;

    assign plain_sum   = hash_step(plain_reg, c_ext);
    assign capital_sum = hash_step(capital_reg, cc_ext);
    assign plain_hit   = (plain_sum == target);
    assign capital_hit = (capital_sum == target);

    always_comb
    begin
        plain_next   = plain_reg;
        capital_next = capital_reg;
        start_next   = start_reg;
        if (advance)
        begin
            if (stage.item.last_char)
            begin
                plain_next   = '0;
                capital_next = '0;
                start_next   = 1'b1;
            end
            else
            begin
                plain_next   = plain_sum;
                capital_next = capital_sum;
                start_next   = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_reg     <= '0;
            capital_reg   <= '0;
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plain_reg     <= plain_next;
            capital_reg   <= capital_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg    <= plain_hit || capital_hit;
            form_reg     <= (!plain_hit && capital_hit) ? FORM_CAPITALIZED : FORM_AS_WRITTEN;
            hash_out_reg <= plain_sum;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.found        = found_reg;
    assign result_out.matched_form = form_reg;
    assign result_out.word_hash    = hash_out_reg;
endmodule

### sv/string_hash_match_with_capitalization.sv
// channel      role    payload
// char_in      sink    char_value (s8), last_char
// result_out   source  found, matched_form, word_hash (s32)
// cfg          write   cfg_wdata (s32) on cfg_we
//
// one character per cycle unless result_out stalls; a result is registered after the input register
// the per-character 31*h + c update of both hashes is a combinational path between hash registers
// rst_n clears both hashes, the target and all valid flags, and sets the word-start flag
// a stalled result_out holds the result; char_in stops once the full input register cannot advance
module string_hash_match_with_capitalization
(
    input  logic                              clk,
    input  logic                              rst_n,
    shm_char_if.sink                          char_in,
    shm_result_if.source                      result_out,
    input  logic                              cfg_we,
    input  logic signed [shm_pkg::HASH_W-1:0] cfg_wdata
);
    import shm_pkg::*;

    logic [HASH_W-1:0] target_reg;
    stage_t            stage;
    logic              advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    shm_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .stage   (stage),
        .advance (advance)
    );

    shm_hash_core u_hash_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .advance    (advance),
        .target     (target_reg),
        .result_out (result_out)
    );
endmodule

### sv/shm_checker.sv
module shm_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              found,
    input logic                              matched_form,
    input logic signed [shm_pkg::HASH_W-1:0] word_hash,
    input logic                              cfg_we,
    input logic signed [shm_pkg::HASH_W-1:0] cfg_wdata
);
    import shm_pkg::*;

    logic [HASH_W-1:0] target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    // input side only blocks when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> out_valid)
        else $error("input stalled without a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_hash))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found && !matched_form |-> word_hash == target_reg)
        else $error("as-written match with wrong hash");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!found || matched_form) |-> word_hash != target_reg)
        else $error("as-written hash equals target but not reported");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> !matched_form)
        else $error("capitalized form flagged without a match");
endmodule

bind string_hash_match_with_capitalization shm_checker u_shm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (char_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .found        (result_out.found),
    .matched_form (result_out.matched_form),
    .word_hash    (result_out.word_hash),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
);
